FILE: sv/cfrc_pkg.sv
package cfrc_pkg;

	localparam int MAX_WORDS = 32;
	localparam int ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int INDEX_W   = 5;
	localparam int TDATA_W   = 72;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_LENGTH = 2'd1;
	localparam logic [1:0] STS_CRC    = 2'd2;
	localparam logic [1:0] STS_ABORT  = 2'd3;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_WORD    = 1'b1;

	localparam logic [1:0] REG_MAGIC_FIRST     = 2'd0;
	localparam logic [1:0] REG_MAGIC_SECOND    = 2'd1;
	localparam logic [1:0] REG_PAYLOAD_COMMAND = 2'd2;

	typedef struct packed {
		logic [7:0] magic_first;
		logic [7:0] magic_second;
		logic [7:0] payload_command;
	} cfg_regs_t;

	// controller -> datapath
	typedef struct packed {
		logic              step;
		logic              load_verdict;
		logic              verdict_last;
		logic              rd_en;
		logic              load_word;
		logic              word_last;
		logic [ADDR_W-1:0] rd_idx;
	} ctl_cmd_t;

	// datapath -> controller, event of the byte currently offered
	typedef struct packed {
		logic              verdict;
		logic              drain;
		logic [ADDR_W-1:0] last_idx;
	} dp_sts_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/command_frame_receiver_crc16.sv
// Command frame receiver with CRC-16/CCITT-FALSE check.
// Slave stream: one received byte per word in s_tdata, s_tuser set to abort the frame.
// Master stream: one result per word; m_tuser tells a frame verdict from a payload
// word, m_tlast marks the final result caused by one input byte.
// Config channel: cfg_index selects magic_first, magic_second or payload_command.
// Input bytes are taken one per cycle while the result register is free or being
// emptied and no payload read-back is under way. A verdict is visible on m_tvalid
// the cycle after the closing byte (last CRC byte, eighth header byte on a length
// error, or an abort after the header). After a good frame of the payload
// command, its N words are read back from the payload RAM one by one (RAM read,
// then load of the result register); s_tready stays low until the last is loaded.
// When m_tready is held low the result register holds its word and s_tready
// drops until it is taken.
// Reset clears the config registers to zero, puts the parser at the start of a
// header with the CRC at 0xFFFF and empties the result register; no memory
// clearing pass is needed.
module command_frame_receiver_crc16 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // rx_byte
	input  logic                          s_tuser,   // abort
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], command[9:2], address[33:10], word_count[49:34],
	// payload_word[65:50], word_index[70:66], zero pad[71]
	output logic [cfrc_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tuser,   // kind
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data
);

	cfrc_pkg::cfg_regs_t cfg_q;
	cfrc_pkg::ctl_cmd_t  cmd;
	cfrc_pkg::dp_sts_t   sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cfrc_pkg::REG_MAGIC_FIRST:     cfg_q.magic_first     <= cfg_data;
				cfrc_pkg::REG_MAGIC_SECOND:    cfg_q.magic_second    <= cfg_data;
				cfrc_pkg::REG_PAYLOAD_COMMAND: cfg_q.payload_command <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cfrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfrc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rx_byte  (s_tdata),
		.abort    (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_tdata),
		.out_kind (m_tuser),
		.out_last (m_tlast)
	);

	// result register is never overwritten while it holds an untaken word
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(cmd.load_verdict || cmd.load_word))
		else $error("result register overwritten");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_verdict && cmd.load_word))
		else $error("verdict and payload word loaded together");

	// a verdict followed by payload words blocks input while draining
	a_drain_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_verdict && !cmd.verdict_last) |=> !s_tready)
		else $error("input accepted during payload drain");

	a_word_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_word |-> $past(cmd.rd_en) || $past(cmd.load_word == 1'b0 && !s_tready))
		else $error("payload word loaded without a RAM read");

endmodule

FILE: sv/cfrc_ram.sv
module cfrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/cfrc_dp.sv
module cfrc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfrc_pkg::cfg_regs_t           cfg,
	input  logic [7:0]                    rx_byte,
	input  logic                          abort,
	input  cfrc_pkg::ctl_cmd_t            cmd,
	output cfrc_pkg::dp_sts_t             sts,
	output logic [cfrc_pkg::TDATA_W-1:0]  out_data,
	output logic                          out_kind,
	output logic                          out_last
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC     = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [6:0]  pos_q, pos_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [7:0]  low_q, low_d;
	logic [7:0]  hdr_q [8];

	logic        hdr_we;
	logic [2:0]  hdr_idx;
	logic        ram_we;
	logic [cfrc_pkg::ADDR_W-1:0] ram_waddr;
	logic [15:0] ram_rdata;

	logic [15:0] crc_upd;
	logic [6:0]  pos_inc;
	logic [15:0] cnt_stored;
	logic [15:0] cnt_eff;
	logic [7:0]  hdr7_eff;
	logic        ev_verdict;
	logic [1:0]  ev_status;
	logic        ev_drain;

	// output word register
	logic        kind_q;
	logic [1:0]  status_q;
	logic [7:0]  command_q;
	logic [23:0] address_q;
	logic [15:0] count_q;
	logic [15:0] word_q;
	logic [cfrc_pkg::INDEX_W-1:0] index_q;
	logic        last_q;

	assign crc_upd    = cfrc_pkg::crc16_byte(crc_q, rx_byte);
	assign pos_inc    = pos_q + 7'd1;
	assign cnt_stored = {hdr_q[6], hdr_q[7]};
	// last header byte is not stored yet when the header closes
	assign hdr7_eff   = (phase_q != PH_PAYLOAD && phase_q != PH_CRC && pos_q[2:0] == 3'd7)
		? rx_byte : hdr_q[7];
	assign cnt_eff    = {hdr_q[6], hdr7_eff};

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		crc_d      = crc_q;
		crc_hi_d   = crc_hi_q;
		low_d      = low_q;
		hdr_we     = 1'b0;
		hdr_idx    = pos_q[2:0];
		ram_we     = 1'b0;
		ram_waddr  = cfrc_pkg::ADDR_W'(pos_q[6:1]);
		ev_verdict = 1'b0;
		ev_status  = cfrc_pkg::STS_OK;
		ev_drain   = 1'b0;
		if (abort) begin
			if (phase_q == PH_PAYLOAD || phase_q == PH_CRC) begin
				ev_verdict = 1'b1;
				ev_status  = cfrc_pkg::STS_ABORT;
			end
			phase_d  = PH_HEADER;
			pos_d    = 7'd0;
			crc_d    = cfrc_pkg::CRC_INIT;
			crc_hi_d = 8'd0;
			low_d    = 8'd0;
		end else begin
			case (phase_q)
				PH_PAYLOAD: begin
					crc_d = crc_upd;
					if (!pos_q[0]) begin
						low_d = rx_byte;
					end else begin
						ram_we = 1'b1;
					end
					pos_d = pos_inc;
					if ({10'd0, pos_inc} >= {cnt_stored, 1'b0}) begin
						phase_d = PH_CRC;
						pos_d   = 7'd0;
					end
				end
				PH_CRC: begin
					if (pos_q == 7'd0) begin
						crc_hi_d = rx_byte;
						pos_d    = 7'd1;
					end else begin
						ev_verdict = 1'b1;
						if ({crc_hi_q, rx_byte} != crc_q) begin
							ev_status = cfrc_pkg::STS_CRC;
						end else begin
							ev_drain = (hdr_q[2] == cfg.payload_command) && (cnt_stored != 16'd0);
						end
						phase_d  = PH_HEADER;
						pos_d    = 7'd0;
						crc_d    = cfrc_pkg::CRC_INIT;
						crc_hi_d = 8'd0;
						low_d    = 8'd0;
					end
				end
				default: begin
					hdr_we = 1'b1;
					crc_d  = crc_upd;
					pos_d  = {4'd0, pos_q[2:0]} + 7'd1;
					if (pos_q[2:0] == 3'd7) begin
						if (hdr_q[0] != cfg.magic_first || hdr_q[1] != cfg.magic_second) begin
							phase_d  = PH_HEADER;
							pos_d    = 7'd0;
							crc_d    = cfrc_pkg::CRC_INIT;
							crc_hi_d = 8'd0;
							low_d    = 8'd0;
						end else if ({16'd0, cnt_eff} > 32'(cfrc_pkg::MAX_WORDS)) begin
							ev_verdict = 1'b1;
							ev_status  = cfrc_pkg::STS_LENGTH;
							phase_d    = PH_HEADER;
							pos_d      = 7'd0;
							crc_d      = cfrc_pkg::CRC_INIT;
							crc_hi_d   = 8'd0;
							low_d      = 8'd0;
						end else begin
							pos_d   = 7'd0;
							phase_d = (hdr_q[2] == cfg.payload_command && cnt_eff != 16'd0)
								? PH_PAYLOAD : PH_CRC;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= 7'd0;
			crc_q    <= cfrc_pkg::CRC_INIT;
			crc_hi_q <= 8'd0;
			low_q    <= 8'd0;
		end else if (cmd.step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			low_q    <= low_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && !abort && hdr_we) begin
			hdr_q[hdr_idx] <= rx_byte;
		end
	end

	cfrc_ram #(
		.WIDTH (16),
		.DEPTH (cfrc_pkg::MAX_WORDS)
	) u_payload_ram (
		.clk   (clk),
		.we    (cmd.step && !abort && ram_we),
		.waddr (ram_waddr),
		.wdata ({rx_byte, low_q}),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_verdict) begin
			kind_q    <= cfrc_pkg::KIND_VERDICT;
			status_q  <= ev_status;
			command_q <= hdr_q[2];
			address_q <= {hdr_q[3], hdr_q[4], hdr_q[5]};
			count_q   <= cnt_eff;
			word_q    <= 16'd0;
			index_q   <= '0;
			last_q    <= cmd.verdict_last;
		end else if (cmd.load_word) begin
			kind_q    <= cfrc_pkg::KIND_WORD;
			status_q  <= cfrc_pkg::STS_OK;
			command_q <= hdr_q[2];
			address_q <= {hdr_q[3], hdr_q[4], hdr_q[5]};
			count_q   <= cnt_stored;
			word_q    <= ram_rdata;
			index_q   <= cfrc_pkg::INDEX_W'(cmd.rd_idx);
			last_q    <= cmd.word_last;
		end
	end

	assign sts.verdict  = ev_verdict;
	assign sts.drain    = ev_drain;
	assign sts.last_idx = cfrc_pkg::ADDR_W'(cnt_stored) - cfrc_pkg::ADDR_W'(1);

	assign out_data = {1'b0, index_q, word_q, count_q, address_q, command_q, status_q};
	assign out_kind = kind_q;
	assign out_last = last_q;

endmodule

FILE: sv/cfrc_ctrl.sv
module cfrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cfrc_pkg::dp_sts_t   sts,
	output cfrc_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_FETCH = 2'd1,
		ST_EMIT  = 2'd2
	} state_t;

	state_t                      state_q;
	logic                        out_valid_q;
	logic [cfrc_pkg::ADDR_W-1:0] idx_q;
	logic                        out_free;
	logic                        accept;
	logic                        word_last;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_RUN) && out_free;
	assign accept    = in_valid && in_ready;
	assign word_last = (idx_q == sts.last_idx);

	always_comb begin
		cmd.step         = accept;
		cmd.load_verdict = accept && sts.verdict;
		cmd.verdict_last = !sts.drain;
		cmd.rd_en        = (state_q == ST_FETCH);
		cmd.rd_idx       = idx_q;
		cmd.load_word    = (state_q == ST_EMIT) && out_free;
		cmd.word_last    = word_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cmd.load_verdict || cmd.load_word) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (accept && sts.verdict && sts.drain) begin
						idx_q   <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (word_last) begin
							state_q <= ST_RUN;
						end else begin
							idx_q   <= idx_q + cfrc_pkg::ADDR_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: verif/tb_command_frame_receiver_crc16.sv
`timescale 1ns / 1ps

typedef enum logic [1:0] {
	PARSE_HEADER,
	PARSE_PAYLOAD,
	PARSE_CRC
} parse_phase_t;

typedef struct {
	logic        kind;
	logic [1:0]  status;
	logic [7:0]  command;
	logic [23:0] address;
	logic [15:0] word_count;
	logic [15:0] payload_word;
	logic [4:0]  word_index;
	logic        last;
} frame_result_t;

// bit-serial CRC-16/CCITT-FALSE step, MSB first
function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
	logic [15:0] c;
	logic        fb;
	c = crc;
	for (int i = 7; i >= 0; i--) begin
		fb = c[15] ^ b[i];
		c  = {c[14:0], 1'b0};
		if (fb) begin
			c = c ^ cfrc_pkg::CRC_POLY;
		end
	end
	return c;
endfunction

class frame_scoreboard;
	cfrc_pkg::cfg_regs_t regs;
	parse_phase_t  phase;
	logic [6:0]    pos;
	logic [7:0]    hdr [8];
	logic [15:0]   crc;
	logic [7:0]    crc_hi;
	logic [7:0]    lo_hold;
	logic [15:0]   words [cfrc_pkg::MAX_WORDS];
	frame_result_t expected_q [$];
	int            errors;

	function new();
		regs   = '0;
		errors = 0;
		foreach (hdr[i]) hdr[i] = 8'h00;
		foreach (words[i]) words[i] = 16'h0000;
		restart();
	endfunction

	function void restart();
		phase   = PARSE_HEADER;
		pos     = 7'd0;
		crc     = cfrc_pkg::CRC_INIT;
		crc_hi  = 8'h00;
		lo_hold = 8'h00;
	endfunction

	function void set_reg(input logic [1:0] idx, input logic [7:0] val);
		case (idx)
			cfrc_pkg::REG_MAGIC_FIRST: begin
				regs.magic_first = val;
			end
			cfrc_pkg::REG_MAGIC_SECOND: begin
				regs.magic_second = val;
			end
			cfrc_pkg::REG_PAYLOAD_COMMAND: begin
				regs.payload_command = val;
			end
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void push_result(input logic kind, input logic [1:0] st, input logic [15:0] w,
			input logic [4:0] idx);
		frame_result_t r;
		r.kind         = kind;
		r.status       = st;
		r.command      = hdr[2];
		r.address      = {hdr[3], hdr[4], hdr[5]};
		r.word_count   = {hdr[6], hdr[7]};
		r.payload_word = w;
		r.word_index   = idx;
		r.last         = 1'b0;
		expected_q.push_back(r);
	endfunction

	// one accepted input word: advance the parser, queue what it emits
	function void note_byte(input logic [7:0] b, input logic ab);
		int unsigned   first;
		int unsigned   cnt;
		int unsigned   w;
		logic [2:0]    p;
		logic [15:0]   got;
		frame_result_t r;
		first = expected_q.size();
		cnt   = 32'({hdr[6], hdr[7]});
		if (ab) begin
			if (phase == PARSE_PAYLOAD || phase == PARSE_CRC) begin
				push_result(cfrc_pkg::KIND_VERDICT, cfrc_pkg::STS_ABORT, 16'h0000, 5'd0);
			end
			restart();
		end else begin
			case (phase)
				PARSE_PAYLOAD: begin
					crc = crc16_ccitt_next(crc, b);
					if (!pos[0]) begin
						lo_hold = b;
					end else begin
						w = 32'(pos >> 1);
						if (w < cfrc_pkg::MAX_WORDS) begin
							words[w] = {b, lo_hold};
						end
					end
					pos = pos + 7'd1;
					if (pos >= 2 * cnt) begin
						phase = PARSE_CRC;
						pos   = 7'd0;
					end
				end
				PARSE_CRC: begin
					if (pos == 7'd0) begin
						crc_hi = b;
						pos    = 7'd1;
					end else begin
						got = {crc_hi, b};
						if (got != crc) begin
							push_result(cfrc_pkg::KIND_VERDICT, cfrc_pkg::STS_CRC,
								16'h0000, 5'd0);
						end else begin
							push_result(cfrc_pkg::KIND_VERDICT, cfrc_pkg::STS_OK,
								16'h0000, 5'd0);
							if (hdr[2] == regs.payload_command) begin
								for (int i = 0; i < cnt && i < cfrc_pkg::MAX_WORDS; i++) begin
									push_result(cfrc_pkg::KIND_WORD, cfrc_pkg::STS_OK,
										words[i], 5'(i));
								end
							end
						end
						restart();
					end
				end
				default: begin
					// unused phase code parses as header
					p      = pos[2:0];
					hdr[p] = b;
					crc    = crc16_ccitt_next(crc, b);
					pos    = {4'd0, p} + 7'd1;
					if (pos >= 7'd8) begin
						cnt = 32'({hdr[6], hdr[7]});
						if (hdr[0] != regs.magic_first || hdr[1] != regs.magic_second) begin
							restart();
						end else if (cnt > cfrc_pkg::MAX_WORDS) begin
							push_result(cfrc_pkg::KIND_VERDICT, cfrc_pkg::STS_LENGTH,
								16'h0000, 5'd0);
							restart();
						end else begin
							pos   = 7'd0;
							phase = (hdr[2] == regs.payload_command && cnt > 0) ?
								PARSE_PAYLOAD : PARSE_CRC;
						end
					end
				end
			endcase
		end
		if (expected_q.size() > first) begin
			r      = expected_q.pop_back();
			r.last = 1'b1;
			expected_q.push_back(r);
		end
	endfunction

	function void compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(input logic [cfrc_pkg::TDATA_W-1:0] d, input logic k,
			input logic l);
		frame_result_t e;
		if (expected_q.size() == 0) begin
			$error("unexpected word: kind %0d status %0d command 0x%0h", k, d[1:0], d[9:2]);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		compare_field("kind", 32'(e.kind), 32'(k));
		compare_field("status", 32'(e.status), 32'(d[1:0]));
		compare_field("command", 32'(e.command), 32'(d[9:2]));
		compare_field("address", 32'(e.address), 32'(d[33:10]));
		compare_field("word_count", 32'(e.word_count), 32'(d[49:34]));
		compare_field("payload_word", 32'(e.payload_word), 32'(d[65:50]));
		compare_field("word_index", 32'(e.word_index), 32'(d[70:66]));
		compare_field("last", 32'(e.last), 32'(l));
	endfunction
endclass

module tb_command_frame_receiver_crc16;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_BYTES   = 80;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata   = 8'h00;
	logic               s_tuser   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [cfrc_pkg::TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 2'd0;
	logic [7:0]         cfg_data  = 8'h00;

	frame_scoreboard sb;
	int              rx_wait = 0;
	bit              tx_no_idle = 1'b0;
	bit              rx_no_idle = 1'b0;
	int              n_sent = 0;
	int              cycles = 0;
	logic [7:0]      frame_q [$];
	logic [7:0]      cur_magic1 = 8'h00;
	logic [7:0]      cur_magic2 = 8'h00;
	logic [7:0]      cur_pcmd   = 8'h00;

	command_frame_receiver_crc16 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_command_frame_receiver_crc16 failed");
			$finish;
		end
	end

	// result sink with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser, m_tlast);
				rx_wait = rx_no_idle ? 0 : $urandom_range(0, 7);
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// called at a rising edge; returns at the edge that accepts the word
	task automatic send_byte(input logic [7:0] b, input logic ab);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= ab;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, ab);
		n_sent++;
	endtask

	task automatic send_frame_q(input int abort_at);
		for (int i = 0; i < frame_q.size(); i++) begin
			if (i == abort_at) begin
				send_byte(8'($urandom), 1'b1);
				return;
			end
			send_byte(frame_q[i], 1'b0);
		end
	endtask

	function automatic void build_frame(input logic [7:0] m1, input logic [7:0] m2,
			input logic [7:0] cmd, input logic [23:0] addr, input logic [15:0] cnt,
			input bit header_only);
		logic [15:0] c;
		frame_q.delete();
		frame_q.push_back(m1);
		frame_q.push_back(m2);
		frame_q.push_back(cmd);
		frame_q.push_back(addr[23:16]);
		frame_q.push_back(addr[15:8]);
		frame_q.push_back(addr[7:0]);
		frame_q.push_back(cnt[15:8]);
		frame_q.push_back(cnt[7:0]);
		if (!header_only) begin
			if (cmd == cur_pcmd) begin
				for (int i = 0; i < 2 * cnt; i++) begin
					frame_q.push_back(8'($urandom));
				end
			end
			c = cfrc_pkg::CRC_INIT;
			foreach (frame_q[i]) c = crc16_ccitt_next(c, frame_q[i]);
			frame_q.push_back(c[15:8]);
			frame_q.push_back(c[7:0]);
		end
	endfunction

	// stop sending and let every queued result come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] m1, input logic [7:0] m2,
			input logic [7:0] pc);
		drain_results();
		write_reg(cfrc_pkg::REG_MAGIC_FIRST, m1);
		write_reg(cfrc_pkg::REG_MAGIC_SECOND, m2);
		write_reg(cfrc_pkg::REG_PAYLOAD_COMMAND, pc);
		cur_magic1 = m1;
		cur_magic2 = m2;
		cur_pcmd   = pc;
	endtask

	task automatic run_directed();
		// good program frame, all-ones address
		build_frame(cur_magic1, cur_magic2, cur_pcmd, 24'hFFFFFF, 16'd1, 1'b0);
		send_frame_q(-1);
		// count one above the limit
		build_frame(cur_magic1, cur_magic2, 8'h00, 24'h000000,
			16'(cfrc_pkg::MAX_WORDS + 1), 1'b1);
		send_frame_q(-1);
		// abort while still in the header: silent
		send_byte(8'hFF, 1'b1);
		// abort right after the header of a program frame
		build_frame(cur_magic1, cur_magic2, cur_pcmd, 24'h000000, 16'd1, 1'b0);
		send_frame_q(8);
		// zero count, other command, broken crc
		build_frame(cur_magic1, cur_magic2, ~cur_pcmd, 24'h5A5A5A, 16'd0, 1'b0);
		frame_q[9] = frame_q[9] ^ 8'h01;
		send_frame_q(-1);
		// wrong second magic byte
		build_frame(cur_magic1, ~cur_magic2, cur_pcmd, 24'h123456, 16'd1, 1'b1);
		send_frame_q(-1);
	endtask

	task automatic send_random_frame();
		int         r;
		int         idx;
		int         n;
		logic [7:0] m1;
		logic [7:0] m2;
		logic [7:0] cmd;
		logic [15:0] cnt;
		tx_no_idle = ($urandom_range(0, 5) == 0);
		rx_no_idle = ($urandom_range(0, 5) == 0);
		r   = $urandom_range(0, 99);
		m1  = cur_magic1;
		m2  = cur_magic2;
		cmd = cur_pcmd;
		cnt = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(5, cfrc_pkg::MAX_WORDS)) :
			16'($urandom_range(0, 4));
		if (r >= 50 && r < 65) begin
			cmd = 8'($urandom);
			if (cmd == cur_pcmd) begin
				cmd = cmd ^ 8'h01;
			end
			cnt = 16'($urandom_range(0, cfrc_pkg::MAX_WORDS));
		end
		if (r >= 75 && r < 80) begin
			case ($urandom_range(0, 2))
				0: begin
					m1 = m1 ^ 8'($urandom_range(1, 255));
				end
				1: begin
					m2 = m2 ^ 8'($urandom_range(1, 255));
				end
				default: begin
					m1 = m1 ^ 8'($urandom_range(1, 255));
					m2 = m2 ^ 8'($urandom_range(1, 255));
				end
			endcase
		end
		if (r >= 80 && r < 86) begin
			cnt = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
				16'($urandom_range(cfrc_pkg::MAX_WORDS + 1, 65535));
		end
		if (r >= 94) begin
			// line noise, then an abort to resync
			n = $urandom_range(1, 6);
			repeat (n) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
			send_byte(8'($urandom), 1'b1);
			return;
		end
		build_frame(m1, m2, cmd, 24'($urandom), cnt, (r >= 75 && r < 86));
		idx = -1;
		if (r >= 65 && r < 75) begin
			// flip one bit of payload or crc
			n = $urandom_range(8, frame_q.size() - 1);
			frame_q[n] = frame_q[n] ^ 8'(1 << $urandom_range(0, 7));
		end
		if (r >= 86 && r < 94) begin
			idx = $urandom_range(0, frame_q.size() - 1);
		end
		send_frame_q(idx);
	endtask

	initial begin
		int target;
		bit paused;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_regs(8'hA5, 8'h5A, 8'h10);
		run_directed();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin
					program_regs(8'h00, 8'h00, 8'h00);
				end
				2: begin
					program_regs(8'hFF, 8'hFF, 8'hFF);
				end
				3, 4: begin
					program_regs(8'($urandom), 8'($urandom), 8'($urandom));
				end
				default: ;
			endcase
			target = n_sent + PHASE_BYTES;
			paused = 1'b0;
			while (n_sent < target) begin
				if (!paused && n_sent >= target - PHASE_BYTES / 2) begin
					drain_results();
					paused = 1'b1;
				end
				send_random_frame();
			end
		end
		drain_results();
		if (sb.errors == 0) begin
			$display("tb_command_frame_receiver_crc16 passed");
		end else begin
			$display("tb_command_frame_receiver_crc16 failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/cfrc_pkg.sv
sv/cfrc_ram.sv
sv/cfrc_dp.sv
sv/cfrc_ctrl.sv
sv/command_frame_receiver_crc16.sv
verif/tb_command_frame_receiver_crc16.sv
